// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the grid peak finder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_CLK(label, clk, rstn, !(cond), msg)

`endif

// ===== hw/rtl/glm_pkg.sv =====
// Package for the grid local maximum finder: widths, register indexes,
// read slot codes and the controller/datapath command and status structs.
package glm_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 5;
  localparam int unsigned ROWS_CFG_W = 11;
  localparam int unsigned COLS_CFG_W = 6;
  localparam int unsigned MAX_ROWS   = 1024;
  localparam int unsigned MAX_COLS   = 32;

  // Three line banks share one RAM; address is {bank, column}.
  localparam int unsigned BANK_W     = 2;
  localparam int unsigned NUM_BANKS  = 3;
  localparam int unsigned RAM_DEPTH  = NUM_BANKS * MAX_COLS;
  localparam int unsigned RAM_AW     = BANK_W + COL_W;

  localparam int unsigned OUT_DATA_W = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [BANK_W-1:0] BANK_0 = 2'd0;
  localparam logic [BANK_W-1:0] BANK_1 = 2'd1;
  localparam logic [BANK_W-1:0] BANK_2 = 2'd2;

  // Read slots of one cell check, issued in this order.
  localparam int unsigned SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_CENTER = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LEFT   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_ABOVE  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_BELOW  = 3'd4;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic              accept;
    logic              load_step;
    logic              load_flush;
    logic              next_flush;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              eval;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic step_needed;
    logic flush_needed;
    logic flush_done;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/grid_local_maximum_finder.sv =====
// Grid local maximum finder, 4-neighbor: top level.
// An item with no check goes straight to the close; a cell check takes five
// reads of the shared line RAM port, a wait for the RAM read data, compare, close.
// The last value of a grid adds a last-row flush: reads, wait and compare per column.
// A peak is held until the next peak or the close; a stalled output holds the compare.
// Reset clears counters and sets both size registers to 1; line RAM is not cleared.
module grid_local_maximum_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic signed [31:0]             s_axis_tdata,  // [31:0] sample_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [glm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [9:0] peak_row, [14:10] peak_col
  output logic                           m_axis_tlast,  // run_last
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [glm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [glm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  glm_pkg::cmd_t             cmd;
  glm_pkg::sts_t             sts;
  logic [glm_pkg::ROW_W-1:0] out_row;
  logic [glm_pkg::COL_W-1:0] out_col;

  assign cfg_ready_o = 1'b1;

  glm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  glm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_col, out_row};

endmodule

// ===== hw/rtl/glm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/glm_ctrl.sv =====
// Controller of the grid peak finder: sequences accept, line reads, cell
// checks, the last-row flush and the counter update. Uses glm_pkg.
`include "assert_macros.svh"

module glm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  glm_pkg::sts_t sts_i,
  output glm_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [glm_pkg::SLOT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic                        flushing_q, flushing_d;

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    flushing_d = flushing_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          rd_cnt_d     = glm_pkg::SLOT_CENTER;
          if (sts_i.step_needed) begin
            cmd_o.load_step = 1'b1;
            flushing_d      = 1'b0;
            state_d         = ST_READ;
          end else if (sts_i.flush_needed) begin
            cmd_o.load_flush = 1'b1;
            flushing_d       = 1'b1;
            state_d          = ST_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_slot = rd_cnt_q;
        if (rd_cnt_q == glm_pkg::SLOT_BELOW) begin
          rd_cnt_d = glm_pkg::SLOT_CENTER;
          state_d  = ST_WAIT;
        end else begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
      end
      ST_WAIT: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        // hold until the output register can take a displaced result
        if (sts_i.out_free) begin
          cmd_o.eval = 1'b1;
          if (flushing_q) begin
            if (sts_i.flush_done) begin
              state_d = ST_FINISH;
            end else begin
              cmd_o.next_flush = 1'b1;
              state_d          = ST_READ;
            end
          end else if (sts_i.flush_needed) begin
            cmd_o.load_flush = 1'b1;
            flushing_d       = 1'b1;
            state_d          = ST_READ;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!sts_i.hold_valid || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= glm_pkg::SLOT_CENTER;
      flushing_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      flushing_q <= flushing_d;
    end
  end

  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, cmd_o.accept |=> !in_ready_o, "ready after accept")
  `ASSERT_NEVER(a_idle_hold_empty, clk_i, rst_ni, (state_q == ST_IDLE) && sts_i.hold_valid, "held result in idle")

endmodule

// ===== hw/rtl/glm_datapath.sv =====
// Datapath of the grid peak finder: config registers, position counters,
// rotating line banks in one RAM, neighbor compare and result buffering.
// Uses glm_pkg and glm_ram.
`include "assert_macros.svh"

module glm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  glm_pkg::cmd_t                     cmd_i,
  output glm_pkg::sts_t                     sts_o,
  input  glm_pkg::value_t                   sample_i,
  input  logic                              cfg_we_i,
  input  logic [glm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [glm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [glm_pkg::ROW_W-1:0]         out_row_o,
  output logic [glm_pkg::COL_W-1:0]         out_col_o,
  output logic                              out_last_o
);

  logic [glm_pkg::ROWS_CFG_W-1:0] rows_cfg_q, rows_eff;
  logic [glm_pkg::COLS_CFG_W-1:0] cols_cfg_q, cols_eff;
  logic [glm_pkg::ROW_W-1:0]      row_q;
  logic [glm_pkg::COL_W-1:0]      col_q;
  logic [glm_pkg::BANK_W-1:0]     new_bank_q, mid_bank_q, old_bank_q;
  logic                           last_col, last_row;

  // current cell check
  logic [glm_pkg::COL_W-1:0]      chk_col_q;
  logic [glm_pkg::ROW_W-1:0]      chk_row_q;
  logic [glm_pkg::BANK_W-1:0]     line_bank_q, above_bank_q, below_bank_q;
  logic                           has_above_q, has_below_q;

  logic                           rd_valid_q;
  logic [glm_pkg::SLOT_W-1:0]     rd_slot_q;
  logic [glm_pkg::RAM_AW-1:0]     raddr;
  logic [glm_pkg::VALUE_W-1:0]    rdata;
  glm_pkg::value_t                center_q, left_q, right_q, above_q, below_q;
  logic                           is_peak;

  logic                           hold_valid_q;
  logic [glm_pkg::ROW_W-1:0]      hold_row_q;
  logic [glm_pkg::COL_W-1:0]      hold_col_q;
  logic                           out_valid_q, out_free, out_load;
  logic [glm_pkg::ROW_W-1:0]      out_row_q;
  logic [glm_pkg::COL_W-1:0]      out_col_q;
  logic                           out_last_q;

  // Clamp the raw register values to the supported range.
  always_comb begin
    if (rows_cfg_q == '0) begin
      rows_eff = glm_pkg::ROWS_CFG_W'(1);
    end else if (rows_cfg_q > glm_pkg::ROWS_CFG_W'(glm_pkg::MAX_ROWS)) begin
      rows_eff = glm_pkg::ROWS_CFG_W'(glm_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_q;
    end
    if (cols_cfg_q == '0) begin
      cols_eff = glm_pkg::COLS_CFG_W'(1);
    end else if (cols_cfg_q > glm_pkg::COLS_CFG_W'(glm_pkg::MAX_COLS)) begin
      cols_eff = glm_pkg::COLS_CFG_W'(glm_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_cfg_q;
    end
  end

  assign last_col = ({1'b0, col_q} + 1'b1) >= cols_eff;
  assign last_row = ({1'b0, row_q} + 1'b1) >= rows_eff;

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.step_needed  = (row_q != '0) && ({1'b0, col_q} < cols_eff);
  assign sts_o.flush_needed = last_col && last_row;
  assign sts_o.flush_done   = ({1'b0, chk_col_q} + 1'b1) >= cols_eff;
  assign sts_o.hold_valid   = hold_valid_q;
  assign sts_o.out_free     = out_free;

  always_comb begin
    case (cmd_i.rd_slot)
      glm_pkg::SLOT_CENTER: raddr = {line_bank_q, chk_col_q};
      glm_pkg::SLOT_LEFT:   raddr = {line_bank_q, chk_col_q - 1'b1};
      glm_pkg::SLOT_RIGHT:  raddr = {line_bank_q, chk_col_q + 1'b1};
      glm_pkg::SLOT_ABOVE:  raddr = {above_bank_q, chk_col_q};
      glm_pkg::SLOT_BELOW:  raddr = {below_bank_q, chk_col_q};
      default:              raddr = {line_bank_q, chk_col_q};
    endcase
  end

  glm_ram #(
    .WIDTH(glm_pkg::VALUE_W),
    .DEPTH(glm_pkg::RAM_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i ({new_bank_q, col_q}),
    .wdata_i (sample_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Neighbors outside the grid drop out of the compare.
  assign is_peak = !(has_above_q && (center_q < above_q))
                && !(has_below_q && (center_q < below_q))
                && !((chk_col_q != '0) && (center_q < left_q))
                && !((({1'b0, chk_col_q} + 1'b1) < cols_eff) && (center_q < right_q));

  assign out_load = (cmd_i.eval && is_peak && hold_valid_q)
                 || (cmd_i.finish && hold_valid_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q   <= glm_pkg::ROWS_CFG_W'(1);
      cols_cfg_q   <= glm_pkg::COLS_CFG_W'(1);
      row_q        <= '0;
      col_q        <= '0;
      new_bank_q   <= glm_pkg::BANK_0;
      mid_bank_q   <= glm_pkg::BANK_1;
      old_bank_q   <= glm_pkg::BANK_2;
      rd_valid_q   <= 1'b0;
      rd_slot_q    <= glm_pkg::SLOT_CENTER;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          glm_pkg::REG_GRID_ROWS: rows_cfg_q <= cfg_data_i;
          glm_pkg::REG_GRID_COLS: cols_cfg_q <= cfg_data_i[glm_pkg::COLS_CFG_W-1:0];
          default: ;
        endcase
      end
      rd_valid_q <= cmd_i.rd_en;
      rd_slot_q  <= cmd_i.rd_slot;
      if (cmd_i.eval && is_peak) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            row_q <= '0;
          end else begin
            // rotate banks: newest becomes middle, middle becomes older
            row_q      <= row_q + 1'b1;
            new_bank_q <= old_bank_q;
            mid_bank_q <= new_bank_q;
            old_bank_q <= mid_bank_q;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_step) begin
      chk_col_q    <= col_q;
      chk_row_q    <= row_q - 1'b1;
      line_bank_q  <= mid_bank_q;
      above_bank_q <= old_bank_q;
      below_bank_q <= new_bank_q;
      has_above_q  <= row_q >= glm_pkg::ROW_W'(2);
      has_below_q  <= 1'b1;
    end else if (cmd_i.load_flush) begin
      chk_col_q    <= '0;
      chk_row_q    <= row_q;
      line_bank_q  <= new_bank_q;
      above_bank_q <= mid_bank_q;
      below_bank_q <= new_bank_q;
      has_above_q  <= row_q != '0;
      has_below_q  <= 1'b0;
    end else if (cmd_i.next_flush) begin
      chk_col_q <= chk_col_q + 1'b1;
    end
    if (rd_valid_q) begin
      case (rd_slot_q)
        glm_pkg::SLOT_CENTER: center_q <= rdata;
        glm_pkg::SLOT_LEFT:   left_q   <= rdata;
        glm_pkg::SLOT_RIGHT:  right_q  <= rdata;
        glm_pkg::SLOT_ABOVE:  above_q  <= rdata;
        glm_pkg::SLOT_BELOW:  below_q  <= rdata;
        default: ;
      endcase
    end
    if (cmd_i.eval && is_peak) begin
      hold_row_q <= chk_row_q;
      hold_col_q <= chk_col_q;
    end
    if (out_load) begin
      out_row_q  <= hold_row_q;
      out_col_q  <= hold_col_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

  `ASSERT_CLK(a_banks_distinct, clk_i, rst_ni, (new_bank_q != mid_bank_q) && (mid_bank_q != old_bank_q) && (new_bank_q != old_bank_q), "line banks overlap")
  `ASSERT_CLK(a_finish_flushes_hold, clk_i, rst_ni, (cmd_i.finish && hold_valid_q) |=> (out_valid_q && out_last_q && !hold_valid_q), "held result not closed")

endmodule
